@@ hw/rtl/pt_comp_pkg.sv @@
// shared types, constants and a helper function for the compensation pipeline
package pt_comp_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_TEMP_COEFS = 2'd0,
        REG_PRESS_LOW  = 2'd1,
        REG_PRESS_HIGH = 2'd2,
        REG_PRESS_NINE = 2'd3
    } t_reg_idx;

    localparam int unsigned CFG_W   = 64;
    localparam int unsigned RAW_W   = 20;
    localparam int unsigned TEMP_W  = 18;
    localparam int unsigned PRESS_W = 24;
    localparam int unsigned DIV_W   = 64;

    localparam logic [32:0] FINE_OFS   = 33'd128000;
    localparam logic [20:0] P_BASE     = 21'd1048576;
    localparam logic [63:0] NUM_SCALE  = 64'd3125;
    localparam logic [63:0] V1_BIAS    = 64'h0000_8000_0000_0000;
    // reciprocal of 100 for a 37-bit right shift
    localparam logic [30:0] RECIP_100  = 31'd1374389535;
    localparam int unsigned RECIP_SH   = 37;

    // temperature calibration words
    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
    } t_temp_coef;

    // pressure calibration words
    typedef struct packed {
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } t_press_coef;

    // word carried alongside the divider
    typedef struct packed {
        logic                temp_valid;
        logic [TEMP_W-1:0]   deg;
        logic                zero;
    } t_div_tag;

    // low 64 bits of a 64-bit word times a signed 16-bit coefficient
    // unsigned 64x16 product, minus x << 16 when the coefficient is negative
    function automatic logic [63:0] mul64x16(input logic [63:0] x, input logic [15:0] c);
        logic [63:0] corr;
        corr = c[15] ? {x[47:0], 16'b0} : 64'b0;
        return x * {48'b0, c} - corr;
    endfunction

endpackage

@@ hw/rtl/pt_comp_temp.sv @@
// fine temperature pipeline, 32-bit wrapping arithmetic over four stages
module pt_comp_temp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [pt_comp_pkg::RAW_W-1:0]      i_adc_t,
    input  logic [pt_comp_pkg::RAW_W-1:0]      i_adc_p,
    input  pt_comp_pkg::t_temp_coef            i_coef,
    output logic                               o_valid,
    output logic [31:0]                        o_fine,
    output logic [pt_comp_pkg::RAW_W-1:0]      o_adc_p
);
    logic [3:0]  r_vld;
    logic [pt_comp_pkg::RAW_W-1:0] r_adc_p [0:3];
    logic [31:0] r_d1, r_d2, r_m1, r_m2, r_a1, r_m3, r_fine;
    logic [31:0] n_d1, n_d2, n_m1, n_m2, n_a1, n_m3, n_fine;
    logic [31:0] t1_ext, t2_ext, t3_ext;

    assign t1_ext = {16'b0, i_coef.t1};
    assign t2_ext = {{16{i_coef.t2[15]}}, i_coef.t2};
    assign t3_ext = {{16{i_coef.t3[15]}}, i_coef.t3};

    // stage math
    always_comb begin
        n_d1   = {15'b0, i_adc_t[19:3]} - {t1_ext[30:0], 1'b0};
        n_d2   = {16'b0, i_adc_t[19:4]} - t1_ext;
        n_m1   = r_d1 * t2_ext;
        n_m2   = r_d2 * r_d2;
        n_a1   = 32'($signed(r_m1) >>> 11);
        n_m3   = 32'($signed(r_m2) >>> 12) * t3_ext;
        n_fine = r_a1 + 32'($signed(r_m3) >>> 14);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        r_d1       <= n_d1;
        r_d2       <= n_d2;
        r_m1       <= n_m1;
        r_m2       <= n_m2;
        r_a1       <= n_a1;
        r_m3       <= n_m3;
        r_fine     <= n_fine;
        r_adc_p[0] <= i_adc_p;
        r_adc_p[1] <= r_adc_p[0];
        r_adc_p[2] <= r_adc_p[1];
        r_adc_p[3] <= r_adc_p[2];
    end

    assign o_valid = r_vld[3];
    assign o_fine  = r_fine;
    assign o_adc_p = r_adc_p[3];
endmodule

@@ hw/rtl/pt_comp_pre.sv @@
// pressure numerator and divisor, plus whole-degree temperature, six stages
module pt_comp_pre (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [31:0]                        i_fine,
    input  logic [pt_comp_pkg::RAW_W-1:0]      i_adc_p,
    input  pt_comp_pkg::t_press_coef           i_coef,
    output logic                               o_valid,
    output logic [63:0]                        o_num,
    output logic [63:0]                        o_den,
    output logic [pt_comp_pkg::TEMP_W-1:0]     o_deg
);
    logic [5:0] r_vld;
    logic [pt_comp_pkg::RAW_W-1:0] r_adc_p [0:3];

    logic signed [32:0] r_v1, n_v1;
    logic [23:0]        r_h, n_h;
    logic [31:0]        f5;
    logic signed [65:0] sq_full;
    logic [63:0]        r_sq, n_sq;
    logic signed [48:0] r_m5, n_m5, r_m2, n_m2, r_m5b, r_m2b;
    logic [23:0]        r_habs, n_habs;
    logic               r_hneg2, r_hneg3;
    logic [63:0]        r_t6, n_t6, r_t3, n_t3;
    logic [54:0]        r_dq, n_dq;
    logic [63:0]        r_v2, n_v2, r_v1b, n_v1b;
    logic [pt_comp_pkg::TEMP_W-1:0] q100;
    logic [pt_comp_pkg::TEMP_W-1:0] r_deg [0:2];
    logic [pt_comp_pkg::TEMP_W-1:0] n_deg;
    logic [63:0]        r_pr, n_pr, r_num0, n_num0;
    logic [20:0]        pb;
    logic [63:0]        r_num, n_num, r_den, n_den;

    // stage math
    always_comb begin
        // offset fine temperature, hundredths of a degree
        n_v1  = $signed({i_fine[31], i_fine}) - $signed(pt_comp_pkg::FINE_OFS);
        f5    = i_fine + {i_fine[29:0], 2'b0} + 32'd128;
        n_h   = f5[31:8];
        // squares and first products
        sq_full = r_v1 * r_v1;
        n_sq    = sq_full[63:0];
        n_m5    = r_v1 * $signed(i_coef.p5);
        n_m2    = r_v1 * $signed(i_coef.p2);
        n_habs  = r_h[23] ? 24'(-r_h) : r_h;
        // coefficient products and divide by 100
        n_t6 = pt_comp_pkg::mul64x16(r_sq, i_coef.p6);
        n_t3 = pt_comp_pkg::mul64x16(r_sq, i_coef.p3);
        n_dq = 55'(r_habs) * 55'(pt_comp_pkg::RECIP_100);
        // partial sums
        n_v2  = r_t6 + ({{15{r_m5b[48]}}, r_m5b} << 17)
              + ({{48{i_coef.p4[15]}}, i_coef.p4} << 35);
        n_v1b = 64'($signed(r_t3) >>> 8) + ({{15{r_m2b[48]}}, r_m2b} << 12);
        q100  = r_dq[pt_comp_pkg::RECIP_SH +: pt_comp_pkg::TEMP_W];
        n_deg = r_hneg3 ? pt_comp_pkg::TEMP_W'(-q100) : q100;
        // divisor product and raw numerator
        n_pr   = (pt_comp_pkg::V1_BIAS + r_v1b) * {48'b0, i_coef.p1};
        pb     = pt_comp_pkg::P_BASE - {1'b0, r_adc_p[3]};
        n_num0 = ({43'b0, pb} << 31) - r_v2;
        // final scaling
        n_den = 64'($signed(r_pr) >>> 33);
        n_num = r_num0 * pt_comp_pkg::NUM_SCALE;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        r_v1       <= n_v1;
        r_h        <= n_h;
        r_adc_p[0] <= i_adc_p;
        r_sq       <= n_sq;
        r_m5       <= n_m5;
        r_m2       <= n_m2;
        r_habs     <= n_habs;
        r_hneg2    <= r_h[23];
        r_adc_p[1] <= r_adc_p[0];
        r_t6       <= n_t6;
        r_t3       <= n_t3;
        r_dq       <= n_dq;
        r_m5b      <= r_m5;
        r_m2b      <= r_m2;
        r_hneg3    <= r_hneg2;
        r_adc_p[2] <= r_adc_p[1];
        r_v2       <= n_v2;
        r_v1b      <= n_v1b;
        r_deg[0]   <= n_deg;
        r_adc_p[3] <= r_adc_p[2];
        r_pr       <= n_pr;
        r_num0     <= n_num0;
        r_deg[1]   <= r_deg[0];
        r_num      <= n_num;
        r_den      <= n_den;
        r_deg[2]   <= r_deg[1];
    end

    assign o_valid = r_vld[5];
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_deg   = r_deg[2];
endmodule

@@ hw/rtl/pt_comp_div.sv @@
// pipelined signed 64-bit restoring divider, one quotient bit per stage
module pt_comp_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [pt_comp_pkg::DIV_W-1:0]      i_num,
    input  logic [pt_comp_pkg::DIV_W-1:0]      i_den,
    input  pt_comp_pkg::t_div_tag              i_tag,
    output logic                               o_valid,
    output logic [pt_comp_pkg::DIV_W-1:0]      o_quot,
    output logic                               o_neg,
    output pt_comp_pkg::t_div_tag              o_tag
);
    localparam int unsigned W = pt_comp_pkg::DIV_W;

    logic                  r_vld [0:W];
    logic [W-1:0]          r_rem [0:W];
    logic [W-1:0]          r_nq  [0:W];
    logic [W-1:0]          r_den [0:W];
    logic                  r_neg [0:W];
    pt_comp_pkg::t_div_tag r_tag [0:W];

    // entry stage: magnitudes and quotient sign
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_nq[0]  <= i_num[W-1] ? W'(-i_num) : i_num;
        r_den[0] <= i_den[W-1] ? W'(-i_den) : i_den;
        r_neg[0] <= i_num[W-1] ^ i_den[W-1];
        r_tag[0] <= i_tag;
    end

    // one compare and subtract per stage
    for (genvar k = 0; k < W; k++) begin : g_step
        logic [W:0]   trial;
        logic         ge;
        logic [W:0]   diff;

        assign trial = {r_rem[k], r_nq[k][W-1]};
        assign ge    = trial >= {1'b0, r_den[k]};
        assign diff  = trial - {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= ge ? diff[W-1:0] : trial[W-1:0];
            r_nq[k+1]  <= {r_nq[k][W-2:0], ge};
            r_den[k+1] <= r_den[k];
            r_neg[k+1] <= r_neg[k];
            r_tag[k+1] <= r_tag[k];
        end
    end

    assign o_valid = r_vld[W];
    assign o_quot  = r_nq[W];
    assign o_neg   = r_neg[W];
    assign o_tag   = r_tag[W];
endmodule

@@ hw/rtl/pt_comp_post.sv @@
// pressure correction after the divide and conversion to pascals, six stages
module pt_comp_post (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [63:0]                        i_quot,
    input  logic                               i_neg,
    input  pt_comp_pkg::t_div_tag              i_tag,
    input  pt_comp_pkg::t_press_coef           i_coef,
    output logic                               o_valid,
    output logic [pt_comp_pkg::TEMP_W-1:0]     o_temp_deg,
    output logic [pt_comp_pkg::PRESS_W-1:0]    o_press_pascal,
    output logic                               o_zero_divisor
);
    logic [5:0]  r_vld;
    pt_comp_pkg::t_div_tag r_tag [0:4];

    logic [63:0] r_p1, r_p2, r_p3, r_p4;
    logic [63:0] s;
    logic [63:0] r_ll, n_ll, r_w2p, n_w2p, r_ss, n_ss, r_w2, r_w2b, r_w1p, n_w1p;
    logic [31:0] r_lh, n_lh;
    logic [63:0] sum3, w1, pf;
    logic [31:0] r_q248;
    logic [31:0] pa_sum;
    logic [pt_comp_pkg::TEMP_W-1:0]  r_deg_o;
    logic [pt_comp_pkg::PRESS_W-1:0] r_pa_o;
    logic        r_zero_o;

    // stage math
    always_comb begin
        s      = 64'($signed(r_p1) >>> 13);
        n_ll   = {32'b0, s[31:0]} * {32'b0, s[31:0]};
        n_lh   = s[31:0] * s[63:32];
        n_w2p  = pt_comp_pkg::mul64x16(r_p1, i_coef.p8);
        n_ss   = r_ll + {r_lh[30:0], 33'b0};
        n_w1p  = pt_comp_pkg::mul64x16(r_ss, i_coef.p9);
        w1     = 64'($signed(r_w1p) >>> 25);
        sum3   = r_p4 + w1 + r_w2b;
        pf     = 64'($signed(sum3) >>> 8) + ({{48{i_coef.p7[15]}}, i_coef.p7} << 4);
        // divide by 256 truncating toward zero
        pa_sum = r_q248 + (r_q248[31] ? 32'd255 : 32'd0);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        r_p1     <= i_neg ? 64'(-i_quot) : i_quot;
        r_tag[0] <= i_tag;
        r_ll     <= n_ll;
        r_lh     <= n_lh;
        r_w2p    <= n_w2p;
        r_p2     <= r_p1;
        r_tag[1] <= r_tag[0];
        r_ss     <= n_ss;
        r_w2     <= 64'($signed(r_w2p) >>> 19);
        r_p3     <= r_p2;
        r_tag[2] <= r_tag[1];
        r_w1p    <= n_w1p;
        r_w2b    <= r_w2;
        r_p4     <= r_p3;
        r_tag[3] <= r_tag[2];
        r_q248   <= pf[31:0];
        r_tag[4] <= r_tag[3];
        r_deg_o  <= r_tag[4].deg;
        r_zero_o <= r_tag[4].zero;
        r_pa_o   <= r_tag[4].zero ? '0 : pa_sum[31:8];
    end

    assign o_valid        = r_vld[5];
    assign o_temp_deg     = r_deg_o;
    assign o_press_pascal = r_pa_o;
    assign o_zero_divisor = r_zero_o;
endmodule

@@ hw/rtl/pressure_temperature_compensation.sv @@
// top level of the barometric compensation pipeline
//
// Usage: raise i_start with a raw temperature and raw pressure word; the
// word is taken on that clock edge. o_busy is always low, so a new word
// can enter on every cycle. The calibration registers are written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only while no
// measurement is in flight, which the block itself does not enforce.
// Each result is on o_temp_deg, o_press_pascal and o_zero_divisor for one
// cycle with o_valid high, in input order. The word passes 81 register
// stages. Throughput is one measurement per clock. The stages are the 64
// one-bit stages of the pressure divider and its entry stage, plus those of
// the temperature math, the numerator setup and the pressure correction.
// Reset clears every valid bit and all calibration registers; words in
// flight are dropped. The receiver cannot stall; results are never held.
module pressure_temperature_compensation (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [pt_comp_pkg::RAW_W-1:0]      i_temperature_raw,
    input  logic [pt_comp_pkg::RAW_W-1:0]      i_pressure_raw,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_idx,
    input  logic [pt_comp_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                               o_valid,
    output logic signed [pt_comp_pkg::TEMP_W-1:0]  o_temp_deg,
    output logic signed [pt_comp_pkg::PRESS_W-1:0] o_press_pascal,
    output logic                               o_zero_divisor
);
    logic [47:0] r_temp_coefs;
    logic [63:0] r_press_low, r_press_high;
    logic [15:0] r_press_nine;

    pt_comp_pkg::t_temp_coef  tcoef;
    pt_comp_pkg::t_press_coef pcoef;

    logic        t_valid;
    logic [31:0] t_fine;
    logic [pt_comp_pkg::RAW_W-1:0] t_adc_p;
    logic        p_valid;
    logic [63:0] p_num, p_den;
    logic [pt_comp_pkg::TEMP_W-1:0] p_deg;
    pt_comp_pkg::t_div_tag p_tag, d_tag;
    logic        d_valid, d_neg;
    logic [63:0] d_quot;
    logic [pt_comp_pkg::TEMP_W-1:0]  q_deg;
    logic [pt_comp_pkg::PRESS_W-1:0] q_pa;

    assign o_busy = 1'b0;

    // calibration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coefs <= '0;
            r_press_low  <= '0;
            r_press_high <= '0;
            r_press_nine <= '0;
        end else if (i_cfg_we) begin
            case (pt_comp_pkg::t_reg_idx'(i_cfg_idx))
                pt_comp_pkg::REG_TEMP_COEFS: r_temp_coefs <= i_cfg_data[47:0];
                pt_comp_pkg::REG_PRESS_LOW:  r_press_low  <= i_cfg_data;
                pt_comp_pkg::REG_PRESS_HIGH: r_press_high <= i_cfg_data;
                pt_comp_pkg::REG_PRESS_NINE: r_press_nine <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // coefficient unpacking
    assign tcoef.t1 = r_temp_coefs[15:0];
    assign tcoef.t2 = r_temp_coefs[31:16];
    assign tcoef.t3 = r_temp_coefs[47:32];
    assign pcoef.p1 = r_press_low[15:0];
    assign pcoef.p2 = r_press_low[31:16];
    assign pcoef.p3 = r_press_low[47:32];
    assign pcoef.p4 = r_press_low[63:48];
    assign pcoef.p5 = r_press_high[15:0];
    assign pcoef.p6 = r_press_high[31:16];
    assign pcoef.p7 = r_press_high[47:32];
    assign pcoef.p8 = r_press_high[63:48];
    assign pcoef.p9 = r_press_nine;

    pt_comp_temp u_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start & ~o_busy),
        .i_adc_t (i_temperature_raw),
        .i_adc_p (i_pressure_raw),
        .i_coef  (tcoef),
        .o_valid (t_valid),
        .o_fine  (t_fine),
        .o_adc_p (t_adc_p)
    );

    pt_comp_pre u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (t_valid),
        .i_fine  (t_fine),
        .i_adc_p (t_adc_p),
        .i_coef  (pcoef),
        .o_valid (p_valid),
        .o_num   (p_num),
        .o_den   (p_den),
        .o_deg   (p_deg)
    );

    // word carried through the divider
    assign p_tag.temp_valid = p_valid;
    assign p_tag.deg        = p_deg;
    assign p_tag.zero       = (p_den == '0);

    pt_comp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (p_valid),
        .i_num   (p_num),
        .i_den   (p_den),
        .i_tag   (p_tag),
        .o_valid (d_valid),
        .o_quot  (d_quot),
        .o_neg   (d_neg),
        .o_tag   (d_tag)
    );

    pt_comp_post u_post (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (d_valid & d_tag.temp_valid),
        .i_quot         (d_quot),
        .i_neg          (d_neg),
        .i_tag          (d_tag),
        .i_coef         (pcoef),
        .o_valid        (o_valid),
        .o_temp_deg     (q_deg),
        .o_press_pascal (q_pa),
        .o_zero_divisor (o_zero_divisor)
    );

    assign o_temp_deg     = $signed(q_deg);
    assign o_press_pascal = $signed(q_pa);
endmodule

@@ tb/tb_pressure_temperature_compensation.sv @@
// self-checking testbench for the pressure and temperature compensation block
`timescale 1ns / 100ps

module tb_pressure_temperature_compensation;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned TAIL_CYCLES    = 100;
    localparam int unsigned CFG_SETTLE     = 3;

    typedef enum logic [1:0] {
        K_MEAS,
        K_CFG,
        K_DRAIN
    } t_kind;

    typedef struct {
        t_kind                 kind;
        logic [19:0]           t_raw;
        logic [19:0]           p_raw;
        int                    gap;
        pt_comp_pkg::t_reg_idx idx;
        logic [63:0]           data;
    } t_pending;

    typedef struct {
        logic signed [pt_comp_pkg::TEMP_W-1:0]  deg;
        logic signed [pt_comp_pkg::PRESS_W-1:0] pa;
        logic                                   zero;
    } t_reading;

    logic                                   i_clk = 1'b0;
    logic                                   i_rst_n = 1'b0;
    logic                                   i_start = 1'b0;
    logic                                   o_busy;
    logic [pt_comp_pkg::RAW_W-1:0]          i_temperature_raw = '0;
    logic [pt_comp_pkg::RAW_W-1:0]          i_pressure_raw = '0;
    logic                                   i_cfg_we = 1'b0;
    logic [1:0]                             i_cfg_idx = '0;
    logic [pt_comp_pkg::CFG_W-1:0]          i_cfg_data = '0;
    logic                                   o_valid;
    logic signed [pt_comp_pkg::TEMP_W-1:0]  o_temp_deg;
    logic signed [pt_comp_pkg::PRESS_W-1:0] o_press_pascal;
    logic                                   o_zero_divisor;

    // mirror of the calibration registers
    logic [47:0] cal_temp = '0;
    logic [63:0] cal_press_low = '0;
    logic [63:0] cal_press_high = '0;
    logic [15:0] cal_nine = '0;

    t_pending pending_words[$];
    t_reading expected_readings[$];
    int       error_count = 0;
    int       settle_cnt = 0;
    int       idle_cycles = 0;

    pressure_temperature_compensation uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_temperature_raw (i_temperature_raw),
        .i_pressure_raw    (i_pressure_raw),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .o_temp_deg        (o_temp_deg),
        .o_press_pascal    (o_press_pascal),
        .o_zero_divisor    (o_zero_divisor)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] sext16(input logic [15:0] c);
        return {{48{c[15]}}, c};
    endfunction

    // compensated reading from the mirrored calibration
    function automatic t_reading compensate(input logic [19:0] t_raw, input logic [19:0] p_raw);
        logic [31:0] t1, t2, t3, d1, d2, m, a1, a2, fine, h32;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] v1, v2, m64, p, s, w1, w2, num, ua, ub, q;
        int          hund, q248;
        t_reading    r;
        t1 = {16'd0, cal_temp[15:0]};
        t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
        p1 = {48'd0, cal_press_low[15:0]};
        p2 = sext16(cal_press_low[31:16]);
        p3 = sext16(cal_press_low[47:32]);
        p4 = sext16(cal_press_low[63:48]);
        p5 = sext16(cal_press_high[15:0]);
        p6 = sext16(cal_press_high[31:16]);
        p7 = sext16(cal_press_high[47:32]);
        p8 = sext16(cal_press_high[63:48]);
        p9 = sext16(cal_nine);
        // temperature, wraps at 32 bits
        d1 = {15'd0, t_raw[19:3]} - (t1 << 1);
        m = d1 * t2;
        a1 = $signed(m) >>> 11;
        d2 = {16'd0, t_raw[19:4]} - t1;
        m = d2 * d2;
        m = $signed(m) >>> 12;
        m = m * t3;
        a2 = $signed(m) >>> 14;
        fine = a1 + a2;
        m = fine * 32'd5 + 32'd128;
        h32 = $signed(m) >>> 8;
        hund = $signed(h32);
        r.deg = hund / 100;
        // pressure, wraps at 64 bits
        v1 = {{32{fine[31]}}, fine} - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        m64 = v1 * v1 * p3;
        m64 = $signed(m64) >>> 8;
        v1 = m64 + ((v1 * p2) << 12);
        m64 = (64'h0000_8000_0000_0000 + v1) * p1;
        v1 = $signed(m64) >>> 33;
        if (v1 == 64'd0) begin
            r.pa = '0;
            r.zero = 1'b1;
        end else begin
            p = 64'd1048576 - {44'd0, p_raw};
            num = ((p << 31) - v2) * 64'd3125;
            // divide on magnitudes so the most negative quotient wraps
            ua = num[63] ? (64'd0 - num) : num;
            ub = v1[63] ? (64'd0 - v1) : v1;
            q = ua / ub;
            p = (num[63] != v1[63]) ? (64'd0 - q) : q;
            s = $signed(p) >>> 13;
            m64 = p9 * s * s;
            w1 = $signed(m64) >>> 25;
            m64 = p8 * p;
            w2 = $signed(m64) >>> 19;
            m64 = p + w1 + w2;
            // arithmetic shift on its own so the add stays out of its context
            m64 = $signed(m64) >>> 8;
            p = m64 + (p7 << 4);
            q248 = $signed(p[31:0]);
            r.pa = q248 / 256;
            r.zero = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // driver: words, register writes and drain points from the pending queue
    always @(posedge i_clk) begin
        logic we_next;
        we_next = 1'b0;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                expected_readings.push_back(compensate(i_temperature_raw, i_pressure_raw));
            end
            if (i_start && o_busy) begin
                // hold the word until taken
            end else if (settle_cnt > 0) begin
                settle_cnt <= settle_cnt - 1;
                i_start <= 1'b0;
            end else if (pending_words.size() == 0) begin
                i_start <= 1'b0;
            end else if (pending_words[0].kind == K_MEAS) begin
                if (pending_words[0].gap > 0) begin
                    pending_words[0].gap--;
                    i_start <= 1'b0;
                end else begin
                    i_start <= 1'b1;
                    i_temperature_raw <= pending_words[0].t_raw;
                    i_pressure_raw <= pending_words[0].p_raw;
                    void'(pending_words.pop_front());
                end
            end else begin
                i_start <= 1'b0;
                // register writes and drains wait for an empty pipeline
                if (!(i_start && !o_busy) && expected_readings.size() == 0) begin
                    if (pending_words[0].kind == K_CFG) begin
                        we_next = 1'b1;
                        i_cfg_idx <= pending_words[0].idx;
                        i_cfg_data <= pending_words[0].data;
                        case (pending_words[0].idx)
                            pt_comp_pkg::REG_TEMP_COEFS:
                                cal_temp <= pending_words[0].data[47:0];
                            pt_comp_pkg::REG_PRESS_LOW:
                                cal_press_low <= pending_words[0].data;
                            pt_comp_pkg::REG_PRESS_HIGH:
                                cal_press_high <= pending_words[0].data;
                            default:
                                cal_nine <= pending_words[0].data[15:0];
                        endcase
                        settle_cnt <= CFG_SETTLE;
                    end
                    void'(pending_words.pop_front());
                end
            end
        end
        i_cfg_we <= we_next;
    end

    // monitor: compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_valid) begin
            if (expected_readings.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                want = expected_readings.pop_front();
                if (o_temp_deg !== want.deg)
                    report_mismatch("temp_deg", o_temp_deg, want.deg);
                if (o_press_pascal !== want.pa)
                    report_mismatch("press_pascal", o_press_pascal, want.pa);
                if (o_zero_divisor !== want.zero)
                    report_mismatch("zero_divisor", o_zero_divisor, want.zero);
            end
        end
    end

    // watchdog on cycles with no traffic
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog timeout at %0t", $realtime);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic add_meas(input logic [19:0] t_raw, input logic [19:0] p_raw, input int gap);
        t_pending w;
        w.kind = K_MEAS;
        w.t_raw = t_raw;
        w.p_raw = p_raw;
        w.gap = gap;
        w.idx = pt_comp_pkg::REG_TEMP_COEFS;
        w.data = '0;
        pending_words.push_back(w);
    endtask

    task automatic add_drain();
        t_pending w;
        w.kind = K_DRAIN;
        w.t_raw = '0;
        w.p_raw = '0;
        w.gap = 0;
        w.idx = pt_comp_pkg::REG_TEMP_COEFS;
        w.data = '0;
        pending_words.push_back(w);
    endtask

    task automatic add_calibration(input logic [63:0] tc, input logic [63:0] pl,
                                   input logic [63:0] ph, input logic [63:0] p9);
        t_pending w;
        pt_comp_pkg::t_reg_idx ids[4];
        logic [63:0] vals[4];
        ids = '{pt_comp_pkg::REG_TEMP_COEFS, pt_comp_pkg::REG_PRESS_LOW,
                pt_comp_pkg::REG_PRESS_HIGH, pt_comp_pkg::REG_PRESS_NINE};
        vals = '{tc, pl, ph, p9};
        add_drain();
        for (int i = 0; i < 4; i++) begin
            w.kind = K_CFG;
            w.t_raw = '0;
            w.p_raw = '0;
            w.gap = 0;
            w.idx = ids[i];
            w.data = vals[i];
            pending_words.push_back(w);
        end
    endtask

    function automatic logic [15:0] edge_slice();
        case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return 16'h7FFF;
            2: return 16'h8000;
            3: return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    function automatic logic [15:0] jitter(input logic [15:0] base);
        return base + 16'($urandom_range(0, 64)) - 16'd32;
    endfunction

    function automatic logic [19:0] draw_raw();
        case ($urandom_range(0, 9))
            0: return 20'h00000;
            1: return 20'hFFFFF;
            default: return 20'($urandom);
        endcase
    endfunction

    // typical calibration of a real part
    localparam logic [15:0] CT1 = 16'd27504, CT2 = 16'd26435, CT3 = -16'sd1000;
    localparam logic [15:0] CP1 = 16'd36477, CP2 = -16'sd10685, CP3 = 16'd3024;
    localparam logic [15:0] CP4 = 16'd2855, CP5 = 16'd140, CP6 = -16'sd7;
    localparam logic [15:0] CP7 = 16'd15500, CP8 = -16'sd14600, CP9 = 16'd6000;

    // stimulus
    initial begin
        int mode, count;
        bit no_gaps;
        logic [63:0] tc, pl, ph, p9;
        // reset calibration: all zero, divisor is zero
        add_meas(20'h00000, 20'h00000, 0);
        add_meas(20'hFFFFF, 20'hFFFFF, 0);
        add_meas(20'h80000, 20'h00001, 2);
        // typical calibration
        add_calibration({16'hDEAD, CT3, CT2, CT1}, {CP4, CP3, CP2, CP1},
                        {CP8, CP7, CP6, CP5}, {48'hFFFF_0000_1234, CP9});
        add_meas(20'd519888, 20'd415148, 0);
        add_meas(20'h00000, 20'h00000, 0);
        add_meas(20'hFFFFF, 20'hFFFFF, 0);
        add_meas(20'h00000, 20'hFFFFF, 1);
        add_meas(20'hFFFFF, 20'h00000, 0);
        // all ones
        add_calibration('1, '1, '1, '1);
        add_meas(20'h00000, 20'h00000, 0);
        add_meas(20'hFFFFF, 20'hFFFFF, 0);
        add_meas(20'h55555, 20'hAAAAA, 0);
        // most negative slices
        add_calibration(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
                        64'h8000_8000_8000_8000, 64'h8000);
        add_meas(20'h00000, 20'hFFFFF, 0);
        add_meas(20'hFFFFF, 20'h00000, 0);
        add_meas(20'hAAAAA, 20'h55555, 0);
        // most positive slices
        add_calibration(64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_FFFF,
                        64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF);
        add_meas(20'h00000, 20'h00000, 0);
        add_meas(20'hFFFFF, 20'hFFFFF, 0);
        // zero P1 forces a zero divisor while temperature still computes
        add_calibration({16'h0, CT3, CT2, CT1}, {CP4, CP3, CP2, 16'h0000},
                        {CP8, CP7, CP6, CP5}, {48'h0, CP9});
        add_meas(20'd519888, 20'd415148, 0);
        add_meas(20'hFFFFF, 20'h00000, 0);

        // random phases
        for (int ph_i = 0; ph_i < 12; ph_i++) begin
            mode = $urandom_range(0, 3);
            if (mode <= 1) begin
                tc = {16'($urandom), jitter(CT3), jitter(CT2), jitter(CT1)};
                pl = {jitter(CP4), jitter(CP3), jitter(CP2), jitter(CP1)};
                ph = {jitter(CP8), jitter(CP7), jitter(CP6), jitter(CP5)};
                p9 = {48'($urandom), jitter(CP9)};
            end else if (mode == 2) begin
                tc = {$urandom, $urandom};
                pl = {$urandom, $urandom};
                ph = {$urandom, $urandom};
                p9 = {$urandom, $urandom};
            end else begin
                tc = {edge_slice(), edge_slice(), edge_slice(), edge_slice()};
                pl = {edge_slice(), edge_slice(), edge_slice(), edge_slice()};
                ph = {edge_slice(), edge_slice(), edge_slice(), edge_slice()};
                p9 = {48'h0, edge_slice()};
            end
            add_calibration(tc, pl, ph, p9);
            no_gaps = ($urandom_range(0, 3) == 0);
            count = $urandom_range(55, 85);
            for (int k = 0; k < count; k++) begin
                add_meas(draw_raw(), draw_raw(), no_gaps ? 0 : draw_gap());
                if ($urandom_range(0, 49) == 0) add_drain();
            end
        end

        // reset, then wait for all traffic to finish
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk);
        while (pending_words.size() != 0 || i_start || expected_readings.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_readings.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
